// ===== rtl/core/usdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// usdt_pkg: shared constants for the seconds-to-civil-datetime converter
// Range limits of the timestamp and the reciprocal constants that replace
// division by fixed divisors. Every reciprocal is ceil(2^k / c), where
// k = N + ceil(log2(c)) for operands below 2^N, so the quotient is exact.
// ----------------------------------------------------------------------------
package usdt_pkg;

	// Timestamps of 0000-01-01 00:00:00 and 9999-12-31 23:59:59
	localparam logic signed [63:0] TS_MIN = -64'sd62167219200;
	localparam logic signed [63:0] TS_MAX = 64'sd253402300799;

	// Days from the start of era -1 to 0000-01-01 (one full era minus 60)
	localparam logic [21:0] DAY_BIAS = 22'd146037;

	// Divisors
	localparam int unsigned DIV_DAY    = 675;     // 86400 / 128
	localparam int unsigned DIV_ERA    = 146097;
	localparam int unsigned DIV_HOUR   = 3600;
	localparam int unsigned DIV_MIN    = 60;
	localparam int unsigned DIV_4YR    = 1460;
	localparam int unsigned DIV_CENT   = 36524;
	localparam int unsigned DIV_YEAR   = 365;
	localparam int unsigned DIV_MONTH  = 153;
	localparam int unsigned DIV_FIVE   = 5;
	localparam int unsigned ERA_YEARS  = 400;

	// Shift amounts
	localparam int unsigned SH_DAY   = 42;
	localparam int unsigned SH_ERA   = 40;
	localparam int unsigned SH_HOUR  = 29;
	localparam int unsigned SH_MIN   = 18;
	localparam int unsigned SH_4YR   = 29;
	localparam int unsigned SH_YEAR  = 27;
	localparam int unsigned SH_MONTH = 19;
	localparam int unsigned SH_FIVE  = 14;

	// Reciprocals
	localparam logic [32:0] RCP_DAY   =
		33'((((64'd1) << SH_DAY) + 64'(DIV_DAY) - 64'd1) / 64'(DIV_DAY));
	localparam logic [22:0] RCP_ERA   =
		23'((((64'd1) << SH_ERA) + 64'(DIV_ERA) - 64'd1) / 64'(DIV_ERA));
	localparam logic [17:0] RCP_HOUR  =
		18'((((64'd1) << SH_HOUR) + 64'(DIV_HOUR) - 64'd1) / 64'(DIV_HOUR));
	localparam logic [12:0] RCP_MIN   =
		13'((((64'd1) << SH_MIN) + 64'(DIV_MIN) - 64'd1) / 64'(DIV_MIN));
	localparam logic [18:0] RCP_4YR   =
		19'((((64'd1) << SH_4YR) + 64'(DIV_4YR) - 64'd1) / 64'(DIV_4YR));
	localparam logic [18:0] RCP_YEAR  =
		19'((((64'd1) << SH_YEAR) + 64'(DIV_YEAR) - 64'd1) / 64'(DIV_YEAR));
	localparam logic [11:0] RCP_MONTH =
		12'((((64'd1) << SH_MONTH) + 64'(DIV_MONTH) - 64'd1) / 64'(DIV_MONTH));
	localparam logic [11:0] RCP_FIVE  =
		12'((((64'd1) << SH_FIVE) + 64'(DIV_FIVE) - 64'd1) / 64'(DIV_FIVE));

	// Century boundaries inside an era, in days of era
	localparam logic [17:0] CENT_1 = 18'd36524;
	localparam logic [17:0] CENT_2 = 18'd73048;
	localparam logic [17:0] CENT_3 = 18'd109572;
	localparam logic [17:0] ERA_LAST = 18'd146096;

endpackage

`default_nettype wire

// ===== rtl/core/unix_seconds_to_civil_datetime_top.sv =====
`default_nettype none
// done is registered: each result passes nine stages plus the output register before done rises.
// Throughput: one timestamp per cycle; busy is held low, the pipeline never stalls.
// Stages 4-7 each hold two reciprocal multiplies or multiply-subtracts; others at most one.
// Reset (arst_n low) clears the stage valid bits and done; data registers are not reset.
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_datetime_top: Unix time to Gregorian date and time
// Range check, floor split into day and second of day, era-based
// civil-from-days, and hour/minute/second split; divisions by reciprocal multiply or compare.
// ----------------------------------------------------------------------------
module unix_seconds_to_civil_datetime_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [63:0] seconds_since_epoch,
	output logic                    done,
	output logic                    status,
	output logic [13:0]             year,
	output logic [3:0]              month,
	output logic [4:0]              day,
	output logic [4:0]              hour,
	output logic [5:0]              minute,
	output logic [5:0]              second
);
	import usdt_pkg::*;

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// range error travels with the data
	logic err_s1, err_s2, err_s3, err_s4, err_s5, err_s6, err_s7, err_s8, err_s9;

	logic [38:0] u_s1;
	logic [31:0] v_s2;
	logic [6:0]  lo_s2;
	logic [21:0] d_s2;
	logic [16:0] sod_s3, sod_s4;
	logic [21:0] dp_s3, dp_s4;
	logic [4:0]  era_s4, era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [4:0]  hr_s4, hr_s5, hr_s6, hr_s7, hr_s8, hr_s9;
	logic [17:0] doe_s5, doe_s6, doe_s7;
	logic [11:0] rh_s5, rh_s6;
	logic [17:0] t_s6;
	logic [5:0]  mn_s6, mn_s7, mn_s8, mn_s9;
	logic [8:0]  yoe_s7, yoe_s8, yoe_s9;
	logic [5:0]  sc_s7, sc_s8, sc_s9;
	logic [8:0]  doy_s8, doy_s9;
	logic [3:0]  mi_s9;

	// the pipeline never stalls
	assign busy = 1'b0;

	// ---------------- stage 1: range check and offset ----------------
	logic        in_rng;
	logic [63:0] ts_off;
	assign in_rng = (seconds_since_epoch >= TS_MIN) && (seconds_since_epoch <= TS_MAX);
	assign ts_off = 64'(seconds_since_epoch - TS_MIN);

	// ---------------- stage 2: day = (u >> 7) / 675 ----------------
	logic [64:0] p_day;
	assign p_day = 65'(u_s1[38:7]) * 65'(RCP_DAY);

	// ---------------- stage 3: second of day, biased day ----------------
	logic [31:0] m675;
	logic [31:0] r675;
	assign m675 = 32'(d_s2) * 32'(DIV_DAY);
	assign r675 = v_s2 - m675;

	// ---------------- stage 4: era and hour ----------------
	logic [44:0] p_era;
	logic [34:0] p_hr;
	assign p_era = 45'(dp_s3) * 45'(RCP_ERA);
	assign p_hr  = 35'(sod_s3) * 35'(RCP_HOUR);

	// ---------------- stage 5: day of era, remainder of hour ----------------
	logic [21:0] m_era;
	logic [16:0] m_hr;
	assign m_era = 22'(era_s4) * 22'(DIV_ERA);
	assign m_hr  = 17'(hr_s4) * 17'(DIV_HOUR);

	// ---------------- stage 6: leap-day corrected day count, minute ----------------
	logic [36:0] p_4yr;
	logic [6:0]  q_4yr;
	logic [2:0]  q_cent;
	logic        q_last;
	logic [24:0] p_mn;
	assign p_4yr  = 37'(doe_s5) * 37'(RCP_4YR);
	assign q_4yr  = p_4yr[35:29];
	assign q_cent = 3'(doe_s5 >= CENT_1) + 3'(doe_s5 >= CENT_2)
		+ 3'(doe_s5 >= CENT_3) + 3'(doe_s5 >= ERA_LAST);
	assign q_last = (doe_s5 == ERA_LAST);
	assign p_mn   = 25'(rh_s5) * 25'(RCP_MIN);

	// ---------------- stage 7: year of era, second ----------------
	logic [36:0] p_yr;
	logic [11:0] m_mn;
	assign p_yr = 37'(t_s6) * 37'(RCP_YEAR);
	assign m_mn = 12'(mn_s6) * 12'(DIV_MIN);

	// ---------------- stage 8: day of year ----------------
	logic [1:0]  q_c100;
	logic [17:0] yr_days;
	always_comb begin
		if (yoe_s7 >= 9'd300) begin
			q_c100 = 2'd3;
		end else if (yoe_s7 >= 9'd200) begin
			q_c100 = 2'd2;
		end else if (yoe_s7 >= 9'd100) begin
			q_c100 = 2'd1;
		end else begin
			q_c100 = 2'd0;
		end
	end
	assign yr_days = 18'(yoe_s7) * 18'(DIV_YEAR) + 18'(yoe_s7[8:2]) - 18'(q_c100);

	// ---------------- stage 9: month index ----------------
	logic [10:0] x_mi;
	logic [22:0] p_mi;
	assign x_mi = 11'(doy_s8) * 11'd5 + 11'd2;
	assign p_mi = 23'(x_mi) * 23'(RCP_MONTH);

	// ---------------- stage 10: day, month, year ----------------
	logic [10:0] x_md;
	logic [22:0] p_md;
	logic [8:0]  mday_off;
	logic        jan_feb;
	logic [14:0] yr_full;
	logic [4:0]  day_n;
	logic [3:0]  mon_n;
	assign x_md     = 11'(mi_s9) * 11'(DIV_MONTH) + 11'd2;
	assign p_md     = 23'(x_md) * 23'(RCP_FIVE);
	assign mday_off = p_md[22:14];
	assign day_n    = 5'(doy_s9 - mday_off + 9'd1);
	assign jan_feb  = (mi_s9 >= 4'd10);
	assign mon_n    = jan_feb ? (mi_s9 - 4'd9) : (mi_s9 + 4'd3);
	assign yr_full  = 15'(yoe_s9) + 15'(era_s9) * 15'(ERA_YEARS) + 15'(jan_feb)
		- 15'(ERA_YEARS);

	// valid bits and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			done   <= vld_s9;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		// stage 1
		err_s1 <= ~in_rng;
		u_s1   <= ts_off[38:0];
		// stage 2
		err_s2 <= err_s1;
		v_s2   <= u_s1[38:7];
		lo_s2  <= u_s1[6:0];
		d_s2   <= p_day[63:42];
		// stage 3
		err_s3 <= err_s2;
		sod_s3 <= {r675[9:0], lo_s2};
		dp_s3  <= d_s2 + DAY_BIAS;
		// stage 4
		err_s4 <= err_s3;
		sod_s4 <= sod_s3;
		dp_s4  <= dp_s3;
		era_s4 <= p_era[44:40];
		hr_s4  <= p_hr[33:29];
		// stage 5
		err_s5 <= err_s4;
		era_s5 <= era_s4;
		hr_s5  <= hr_s4;
		doe_s5 <= 18'(dp_s4 - m_era);
		rh_s5  <= 12'(sod_s4 - m_hr);
		// stage 6
		err_s6 <= err_s5;
		era_s6 <= era_s5;
		hr_s6  <= hr_s5;
		doe_s6 <= doe_s5;
		rh_s6  <= rh_s5;
		t_s6   <= doe_s5 - 18'(q_4yr) + 18'(q_cent) - 18'(q_last);
		mn_s6  <= p_mn[23:18];
		// stage 7
		err_s7 <= err_s6;
		era_s7 <= era_s6;
		hr_s7  <= hr_s6;
		doe_s7 <= doe_s6;
		mn_s7  <= mn_s6;
		yoe_s7 <= p_yr[35:27];
		sc_s7  <= 6'(rh_s6 - m_mn);
		// stage 8
		err_s8 <= err_s7;
		era_s8 <= era_s7;
		hr_s8  <= hr_s7;
		mn_s8  <= mn_s7;
		sc_s8  <= sc_s7;
		yoe_s8 <= yoe_s7;
		doy_s8 <= 9'(doe_s7 - yr_days);
		// stage 9
		err_s9 <= err_s8;
		era_s9 <= era_s8;
		hr_s9  <= hr_s8;
		mn_s9  <= mn_s8;
		sc_s9  <= sc_s8;
		yoe_s9 <= yoe_s8;
		doy_s9 <= doy_s8;
		mi_s9  <= p_mi[22:19];
		// output register, fields zeroed on range error
		status <= err_s9;
		year   <= err_s9 ? 14'd0 : yr_full[13:0];
		month  <= err_s9 ? 4'd0 : mon_n;
		day    <= err_s9 ? 5'd0 : day_n;
		hour   <= err_s9 ? 5'd0 : hr_s9;
		minute <= err_s9 ? 6'd0 : mn_s9;
		second <= err_s9 ? 6'd0 : sc_s9;
	end

endmodule

`default_nettype wire

// ===== tb/tb_unix_seconds_to_civil_datetime_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_civil_datetime_top: Unix seconds to civil datetime test
// Drives signed 64-bit timestamps in bursts with random gaps, predicts each
// date and time with a behavioral floor-division and civil-from-days model,
// and compares every done strobe field by field in transfer order.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_civil_datetime_top;
	import usdt_pkg::TS_MIN;
	import usdt_pkg::TS_MAX;

	// Status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Calendar constants
	localparam longint SECS_PER_DAY  = 86400;
	localparam longint SECS_PER_HOUR = 3600;
	localparam longint SECS_PER_MIN  = 60;
	localparam longint DAYS_PER_ERA  = 146097;
	localparam longint EPOCH_SHIFT   = 719468;
	localparam longint YEAR_LAST     = 9999;
	localparam int     PIPE_LATENCY  = 10;

	typedef struct {
		longint      stamp;
		logic        status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} civil_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [63:0] seconds_since_epoch;
	logic               done;
	logic               status;
	logic [13:0]        year;
	logic [3:0]         month;
	logic [4:0]         day;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second;

	civil_t pending_dates[$];
	int     error_count;
	int     burst_left;

	unix_seconds_to_civil_datetime_top u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.seconds_since_epoch (seconds_since_epoch),
		.done                (done),
		.status              (status),
		.year                (year),
		.month               (month),
		.day                 (day),
		.hour                (hour),
		.minute              (minute),
		.second              (second)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Division rounding toward minus infinity, remainder always non-negative
	function automatic longint floor_quot(input longint num, input longint den,
			output longint rem);
		longint q;
		q = num / den;
		rem = num % den;
		if (rem < 0) begin
			rem = rem + den;
			q = q - 1;
		end
		return q;
	endfunction

	// Expected date and time for one timestamp
	function automatic civil_t civil_from_unix(input longint ts);
		longint day_count, sod, shifted, era, doe_wide, yr;
		int unsigned doe, yoe, doy, mp, mon, dom;
		civil_t c;
		c.stamp = ts;
		day_count = floor_quot(ts, SECS_PER_DAY, sod);
		shifted = day_count + EPOCH_SHIFT;
		era = floor_quot(shifted, DAYS_PER_ERA, doe_wide);
		doe = doe_wide[31:0];
		yoe = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
		doy = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
		mp = (32'd5 * doy + 32'd2) / 32'd153;
		dom = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
		mon = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
		yr = era * 400 + $signed({32'd0, yoe});
		if (mon <= 32'd2)
			yr = yr + 1;
		if (yr < 0 || yr > YEAR_LAST) begin
			c.status = STATUS_RANGE;
			c.year = '0;
			c.month = '0;
			c.day = '0;
			c.hour = '0;
			c.minute = '0;
			c.second = '0;
		end else begin
			c.status = STATUS_OK;
			c.year = yr[13:0];
			c.month = mon[3:0];
			c.day = dom[4:0];
			c.hour = 5'(sod / SECS_PER_HOUR);
			c.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
			c.second = 6'(sod % SECS_PER_MIN);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint stamp,
			input longint got, input longint want);
		if (error_count < 100)
			$display("MISMATCH %s ts=%0d got=%0d exp=%0d", what, stamp, got, want);
		error_count++;
	endtask

	// One transfer; the sender idles between bursts of random length
	task automatic send_timestamp(input longint ts);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		start <= 1'b1;
		seconds_since_epoch <= ts;
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(civil_from_unix(ts));
		burst_left--;
	endtask

	// Sender holds off until every pending result has arrived
	task automatic drain_results();
		start <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	// Result checker: done marks a one-cycle transfer
	always @(posedge clk) begin
		civil_t want;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("unexpected result", 0, 0, 0);
			end else begin
				want = pending_dates.pop_front();
				if (status !== want.status)
					report_mismatch("status", want.stamp, status, want.status);
				if (year !== want.year)
					report_mismatch("year", want.stamp, year, want.year);
				if (month !== want.month)
					report_mismatch("month", want.stamp, month, want.month);
				if (day !== want.day)
					report_mismatch("day", want.stamp, day, want.day);
				if (hour !== want.hour)
					report_mismatch("hour", want.stamp, hour, want.hour);
				if (minute !== want.minute)
					report_mismatch("minute", want.stamp, minute, want.minute);
				if (second !== want.second)
					report_mismatch("second", want.stamp, second, want.second);
			end
		end
	end

	// Range limits, integer extremes and bit patterns
	task automatic test_extremes();
		send_timestamp(0);
		send_timestamp(-1);
		send_timestamp(TS_MIN);
		send_timestamp(TS_MIN - 1);
		send_timestamp(TS_MAX);
		send_timestamp(TS_MAX + 1);
		send_timestamp(64'sh8000_0000_0000_0000);
		send_timestamp(64'sh7FFF_FFFF_FFFF_FFFF);
		send_timestamp(64'shAAAA_AAAA_AAAA_AAAA);
		send_timestamp(64'sh5555_5555_5555_5555);
	endtask

	// Day, leap and era boundaries on both sides of the epoch
	task automatic test_calendar_edges();
		send_timestamp(86399);
		send_timestamp(86400);
		send_timestamp(-86400);
		send_timestamp(-86401);
		send_timestamp(951782400);      // 2000-02-29 start
		send_timestamp(951868799);      // last second before an era start
		send_timestamp(951868800);      // 2000-03-01, era start
		send_timestamp(-2203891201);    // 1900-02-28, century not leap
		send_timestamp(4107542399);     // 2100-02-28 end
		send_timestamp(-11670912000);   // 1600-03-01, era start below epoch
		send_timestamp(-62162035201);   // 0000-02-29 end
		send_timestamp(-62162035200);   // 0000-03-01, first day of era 0
		send_timestamp(2147483648);     // just past 32-bit signed time
		send_timestamp(1735689599);     // end of a leap year
	endtask

	// Mostly timestamps inside the valid span, plus edges and raw patterns
	task automatic test_random_mix(input int count);
		longint unsigned span, r;
		longint ts, dnum;
		span = longint'(TS_MAX - TS_MIN) + 1;
		for (int i = 0; i < count; i++) begin
			r = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: ts = TS_MIN + longint'(r % span);
				5: ts = (($urandom_range(0, 1) == 0) ? TS_MIN : TS_MAX)
					+ longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
				6, 7: begin
					// midnight edges land on random days in the valid span
					dnum = longint'($urandom_range(0, 3652424)) - 719528;
					ts = dnum * SECS_PER_DAY + longint'($urandom_range(0, 2)) - 1;
				end
				8: ts = longint'(r);
				default: ts = $signed({{32{r[31]}}, r[31:0]});
			endcase
			send_timestamp(ts);
		end
	endtask

	// Full 64-bit random patterns, so every input bit toggles
	task automatic test_random_raw(input int count);
		for (int i = 0; i < count; i++)
			send_timestamp({$urandom, $urandom});
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		seconds_since_epoch <= '0;
		error_count = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_calendar_edges();
		drain_results();
		test_random_mix(320);
		drain_results();
		test_random_raw(60);
		drain_results();
		repeat (PIPE_LATENCY + 10) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#200000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== unix_seconds_to_civil_datetime_top.f =====
rtl/core/usdt_pkg.sv
rtl/core/unix_seconds_to_civil_datetime_top.sv
tb/tb_unix_seconds_to_civil_datetime_top.sv
